// ----- src/isrt_pkg.sv -----
// ----------------------------------------------------------------------------
// isrt_pkg
// shared types and constants for the insertion sorter chain
// ----------------------------------------------------------------------------
package isrt_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int VALUE_W   = 32;
   localparam int SHIFT_W   = 11;
   localparam int PASS_W    = 6;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      last_out;
      logic [SHIFT_W-1:0]        shift_count;
      logic [PASS_W-1:0]         pass_count;
      logic                      overflow;
   } rsp_type;

   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
      logic                      greater;
   } cell_link_type;

   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctrl_type;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } ctrl_state_type;

endpackage

// ----- src/isrt_cell.sv -----
// ----------------------------------------------------------------------------
// isrt_cell
// one slot of the sorted chain: compares against the key, shifts up on
// insert and down on drain
// ----------------------------------------------------------------------------
module isrt_cell
   import isrt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [VALUE_W-1:0] key,
   input  cell_ctrl_type             ctrl,
   input  cell_link_type             lower,
   input  cell_link_type             upper,
   output cell_link_type             link_out,
   output logic                      edge_out
);

   logic                      valid_ff, valid_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      greater;

   always_comb begin
      greater  = valid_ff && (value_ff > key);
      edge_out = greater && !lower.greater;
      link_out = '{valid: valid_ff, value: value_ff, greater: greater};
   end

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      priority if (ctrl.drain) begin
         valid_in = upper.valid;
         value_in = upper.value;
      end else if (ctrl.insert) begin
         priority if (lower.greater) begin
            valid_in = 1'b1;
            value_in = lower.value;
         end else if (greater || (!valid_ff && lower.valid)) begin
            valid_in = 1'b1;
            value_in = key;
         end else begin
            valid_in = valid_ff;
            value_in = value_ff;
         end
      end else begin
         valid_in = valid_ff;
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ----- src/isrt_shift_acc.sv -----
// ----------------------------------------------------------------------------
// isrt_shift_acc
// shift counter: encodes the insertion point in the cycle after the insert and
// adds the number of moved elements
// ----------------------------------------------------------------------------
module isrt_shift_acc
   import isrt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 sample,
   input  logic [MAX_ITEMS-1:0] edge_vec,
   input  logic [CNT_W-1:0]     fill,
   input  logic                 clear,
   output logic [SHIFT_W-1:0]   shift_total
);

   logic                 pend_valid_ff;
   logic [MAX_ITEMS-1:0] edge_ff;
   logic [CNT_W-1:0]     fill_snap_ff;
   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic [IDX_W-1:0]     pos;
   logic [CNT_W-1:0]     moved;

   always_comb begin
      pos = '0;
      for (int i = 0; i < MAX_ITEMS; i++) begin
         if (edge_ff[i]) begin
            pos = pos | IDX_W'(i);
         end
      end
      moved = fill_snap_ff - {{(CNT_W-IDX_W){1'b0}}, pos};
      if (pend_valid_ff && (|edge_ff)) begin
         shift_total = shift_ff + {{(SHIFT_W-CNT_W){1'b0}}, moved};
      end else begin
         shift_total = shift_ff;
      end
      shift_in = clear ? '0 : shift_total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         shift_ff      <= '0;
      end else begin
         pend_valid_ff <= sample;
         shift_ff      <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_ff      <= edge_vec;
      fill_snap_ff <= fill;
   end

endmodule

// ----- src/insertion_sorter.sv -----
// ----------------------------------------------------------------------------
// insertion_sorter
// streaming insertion sort over a chain of MAX_ITEMS compare-and-shift cells
// the last transfer of a set moves the chain to ST_DRAIN, which registers the first result
// throughput: one input per cycle while filling; n results at one per cycle while
//   rsp_stall is low, during which the input is stalled
// reset: synchronous, empties the chain and clears the fill and shift counters and flags
// ----------------------------------------------------------------------------
module insertion_sorter
   import isrt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctrl_state_type state_ff, state_in;

   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [PASS_W-1:0]   pass_ff, pass_in;
   logic                overflow_ff, overflow_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                req_fire;
   logic                full;
   logic                drain_load;
   logic                drain_done;
   logic [SHIFT_W-1:0]  shift_total;
   cell_ctrl_type       cell_ctrl;
   cell_link_type       links [MAX_ITEMS+1];
   cell_link_type       uppers [MAX_ITEMS];
   logic [MAX_ITEMS-1:0] edge_vec;
   logic [MAX_ITEMS-1:0] valid_vec;

   assign links[0] = '{valid: 1'b1, value: '0, greater: 1'b0};

   for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
      if (g == MAX_ITEMS - 1) begin : g_top
         assign uppers[g] = '{valid: 1'b0, value: '0, greater: 1'b0};
      end else begin : g_mid
         assign uppers[g] = links[g+2];
      end
      assign valid_vec[g] = links[g+1].valid;

      isrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .key      (req_data.value),
         .ctrl     (cell_ctrl),
         .lower    (links[g]),
         .upper    (uppers[g]),
         .link_out (links[g+1]),
         .edge_out (edge_vec[g])
      );
   end

   isrt_shift_acc u_shift_acc (
      .clock       (clock),
      .reset       (reset),
      .sample      (cell_ctrl.insert),
      .edge_vec    (edge_vec),
      .fill        (fill_ff),
      .clear       (drain_done),
      .shift_total (shift_total)
   );

   assign req_stall = (state_ff == ST_DRAIN);
   assign req_fire  = req_valid && !req_stall;
   assign full      = (fill_ff == CNT_W'(MAX_ITEMS));

   always_comb begin
      drain_load = (state_ff == ST_DRAIN) && (!rsp_valid_ff || !rsp_stall);
      drain_done = drain_load && (fill_ff == CNT_W'(1));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (req_fire && req_data.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_done) begin
               state_in = ST_FILL;
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cell_ctrl.insert = req_fire && !full;
      cell_ctrl.drain  = drain_load;
      fill_in          = fill_ff;
      pass_in          = pass_ff;
      overflow_in      = overflow_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_in           = rsp_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (req_fire) begin
               if (full) begin
                  overflow_in = 1'b1;
                  pass_in     = PASS_W'(fill_ff - CNT_W'(1));
               end else begin
                  fill_in = fill_ff + CNT_W'(1);
                  pass_in = PASS_W'(fill_ff);
               end
            end
         end
         ST_DRAIN: begin
            if (drain_load) begin
               rsp_valid_in        = 1'b1;
               rsp_in.sorted_value = links[1].value;
               rsp_in.last_out     = drain_done;
               rsp_in.shift_count  = shift_total;
               rsp_in.pass_count   = pass_ff;
               rsp_in.overflow     = overflow_ff;
               fill_in             = fill_ff - CNT_W'(1);
               if (drain_done) begin
                  overflow_in = 1'b0;
               end
            end
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_ff      <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_ff <= pass_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // occupied cells form a contiguous run from the bottom
   assert property (@(posedge clock) disable iff (reset)
      (valid_vec & ~{valid_vec[MAX_ITEMS-2:0], 1'b1}) == '0)
      else $error("chain occupancy has a hole");

   // cell occupancy matches the fill count while collecting
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> ($countones(valid_vec) == int'(fill_ff)))
      else $error("fill count out of step with chain");

   // a drain never starts or runs on an empty chain
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (fill_ff != '0))
      else $error("drain with empty chain");

   // a transfer into a full chain raises the overflow flag
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && full) |=> overflow_ff)
      else $error("overflow not flagged");

endmodule
